@@ sv/assert_macros.svh @@
// Assertion macros used by the RTL module of the cartridge mapper.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/cmirq_pkg.sv @@
// Shared types and constants of the cartridge mapper.
// No dependencies; imported by cart_mapper_irq_ext_attribute.
package cmirq_pkg;

	localparam int ATTR_ENTRIES = 1024;
	localparam int ATTR_AW      = $clog2(ATTR_ENTRIES);
	localparam int TABLE_DEPTH  = 2 * ATTR_ENTRIES;
	localparam int TABLE_AW     = $clog2(TABLE_DEPTH);

	// Event kinds carried on the request's tuser
	localparam logic [2:0] OP_CPU_WR = 3'd0;
	localparam logic [2:0] OP_CPU_RD = 3'd1;
	localparam logic [2:0] OP_PPU_RD = 3'd2;
	localparam logic [2:0] OP_TICK   = 3'd3;
	localparam logic [2:0] OP_SRESET = 3'd4;

	// Register select (addr bits 2..0) inside 8000-BFFF
	localparam logic [2:0] REG_IRQ_LATCH = 3'd0;
	localparam logic [2:0] REG_IRQ_CTRL  = 3'd1;
	localparam logic [2:0] REG_CONTROL   = 3'd2;
	localparam logic [2:0] REG_PRG       = 3'd3;

	// Cartridge mirroring codes
	localparam logic [1:0] MIR_VERT = 2'd0;
	localparam logic [1:0] MIR_HORZ = 2'd1;
	localparam logic [1:0] MIR_ONE0 = 2'd2;
	localparam logic [1:0] MIR_ONE1 = 2'd3;

	localparam logic [9:0] NT_ATTR_BASE = 10'h3C0;
	localparam logic [6:0] JUMPER_BASE  = 7'h64;

	typedef logic [7:0] attr_lut_t [4];
	localparam attr_lut_t ATTR_EXPAND = '{8'h00, 8'h55, 8'hAA, 8'hFF};

	// Banking and IRQ status shown with every result; first field in the MSBs
	typedef struct packed {
		logic       irq_line;
		logic       wram_enable;
		logic [1:0] mirror_mode;
		logic [3:0] chr_bank_d;
		logic [3:0] chr_bank_c;
		logic [3:0] chr_bank_b;
		logic [3:0] chr_bank_a;
		logic [3:0] prg_bank;
	} status_t;

	function automatic logic [7:0] attr_expand(input logic [1:0] v);
		return ATTR_EXPAND[v];
	endfunction

endpackage

@@ sv/cmirq_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module cmirq_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/cart_mapper_irq_ext_attribute.sv @@
// Cartridge mapper with countdown IRQ, banking registers and extended attributes.
// Depends on cmirq_pkg, cmirq_ram and assert_macros.svh.
//
// One request per cycle is taken, sustained while no result stalls and no
// clearing pass runs: every event (CPU write, CPU read, PPU read, tick, soft
// reset) updates the register state at the edge it is accepted and leaves one
// result through stage s1 and then the output register. The 2048 x 2-bit
// attribute table lives in a synchronous RAM with one write and one read
// port; a PPU attribute fetch reads it at accept and the data joins the
// result in s1. After reset a clearing pass zeroes all 2048 entries, one per
// cycle; requests are held off (s_tready low) during that pass, while
// cart_mirror writes are taken. A stalled result lets a new request enter
// only an empty s1; once s1 is full it holds and s_tready drops.
module cart_mapper_irq_ext_attribute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // addr[15:0], wdata[23:16], cycles[31:24]
	input  logic [2:0]  s_tuser,   // op[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// rdata[7:0], rdata_hit[8], sound_access[9], prg_bank[13:10],
	// chr_bank_a[17:14], chr_bank_b[21:18], chr_bank_c[25:22],
	// chr_bank_d[29:26], mirror_mode[31:30], wram_enable[32], irq_line[33]
	output logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata  // cart_mirror
);
	import cmirq_pkg::*;

	// Request fields
	logic [2:0]  op;
	logic [15:0] addr;
	logic [7:0]  wdata;
	logic [7:0]  cycles;

	assign op     = s_tuser;
	assign addr   = s_tdata[15:0];
	assign wdata  = s_tdata[23:16];
	assign cycles = s_tdata[31:24];

	// Architectural state
	logic [1:0]        cart_mirror_q;
	logic              jumper_q;
	logic [3:0]        control_q;
	logic [3:0]        prg_q;
	logic [3:0]        chr_q [4];
	logic              irq_en_q;
	logic [7:0]        irq_latch_q;
	logic [16:0]       irq_cnt_q;
	logic [ATTR_AW-1:0] tile_q;
	logic              irq_pend_q;

	// Clearing pass counter: MSB set when the pass is done
	logic [TABLE_AW:0] clr_q;
	logic              clr_busy;

	// Pipeline
	logic       s1_valid_q;
	logic       s1_attr_s1;
	logic [7:0] rdata_s1;
	logic       hit_s1;
	logic       snd_s1;
	status_t    status_s1;

	logic       out_valid_q;
	logic [7:0] out_rdata_q;
	logic       out_hit_q;
	logic       out_snd_q;
	status_t    out_status_q;

	logic accept;
	logic advance;

	assign clr_busy = !clr_q[TABLE_AW];
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !clr_busy && (!s1_valid_q || advance);
	assign accept   = s_tvalid && s_tready;

	// Decode
	logic in_low, in_high;
	logic wr_reg, wr_snd, wr_attr;
	logic rd_jumper, rd_snd;
	logic ppu_nt, ppu_attr, ppu_tile;
	logic is_tick, is_sreset;
	logic half;

	always_comb begin
		in_low    = addr[15:14] == 2'b10;
		in_high   = addr[15:14] == 2'b11;
		wr_reg    = (op == OP_CPU_WR) && in_low && addr[3];
		wr_snd    = (op == OP_CPU_WR) && in_low && !addr[3];
		wr_attr   = (op == OP_CPU_WR) && in_high;
		rd_jumper = (op == OP_CPU_RD) && (addr[15:11] == 5'b01001);
		rd_snd    = (op == OP_CPU_RD) && (addr[15:12] == 4'h5);
		ppu_nt    = (op == OP_PPU_RD) && (addr > 16'h2000) && (addr < 16'h3F00)
			&& control_q[2];
		ppu_attr  = ppu_nt && (addr[9:0] >= NT_ATTR_BASE);
		ppu_tile  = ppu_nt && !ppu_attr;
		is_tick   = op == OP_TICK;
		is_sreset = op == OP_SRESET;
		case (cart_mirror_q)
			MIR_VERT: half = addr[11];
			MIR_HORZ: half = addr[10];
			MIR_ONE0: half = 1'b0;
			MIR_ONE1: half = 1'b1;
			default:  half = 1'b0;
		endcase
	end

	// Next state for the accepted request
	logic [3:0]  control_nxt, prg_nxt;
	logic [3:0]  chr_nxt [4];
	logic        irq_en_nxt, irq_pend_nxt;
	logic [7:0]  irq_latch_nxt;
	logic [16:0] irq_cnt_nxt;
	logic [16:0] irq_dec;
	logic        irq_fire;

	always_comb begin
		control_nxt   = control_q;
		prg_nxt       = prg_q;
		chr_nxt       = chr_q;
		irq_en_nxt    = irq_en_q;
		irq_pend_nxt  = irq_pend_q;
		irq_latch_nxt = irq_latch_q;
		irq_cnt_nxt   = irq_cnt_q;
		// Counter never drops below -255, so 17 bits hold the difference
		irq_dec  = irq_cnt_q - {9'd0, cycles};
		irq_fire = irq_dec[16] || (irq_dec == '0);
		if (wr_reg) begin
			case (addr[2:0])
				REG_IRQ_LATCH: irq_latch_nxt = wdata;
				REG_IRQ_CTRL: begin
					irq_cnt_nxt  = {2'b00, wdata[6:0], irq_latch_q};
					irq_en_nxt   = wdata[7];
					irq_pend_nxt = 1'b0;
				end
				REG_CONTROL: control_nxt = wdata[3:0];
				REG_PRG:     prg_nxt     = wdata[3:0];
				default:     chr_nxt[addr[1:0]] = wdata[3:0];
			endcase
		end
		if (is_tick && irq_en_q) begin
			irq_cnt_nxt = irq_dec;
			if (irq_fire) begin
				irq_en_nxt   = 1'b0;
				irq_pend_nxt = 1'b1;
			end
		end
	end

	status_t status_nxt;

	always_comb begin
		status_nxt.irq_line    = irq_pend_nxt;
		status_nxt.wram_enable = control_nxt[3];
		status_nxt.mirror_mode = control_nxt[1:0];
		status_nxt.chr_bank_d  = chr_nxt[3];
		status_nxt.chr_bank_c  = chr_nxt[2];
		status_nxt.chr_bank_b  = chr_nxt[1];
		status_nxt.chr_bank_a  = chr_nxt[0];
		status_nxt.prg_bank    = prg_nxt;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_mirror_q <= MIR_VERT;
		end else if (cfg_we) begin
			cart_mirror_q <= cfg_wdata;
		end
	end

	// Clearing pass: advance one table entry per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clr_busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Register state: commit on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jumper_q    <= 1'b0;
			control_q   <= '0;
			prg_q       <= '0;
			chr_q[0]    <= 4'd0;
			chr_q[1]    <= 4'd1;
			chr_q[2]    <= 4'd2;
			chr_q[3]    <= 4'd3;
			irq_en_q    <= 1'b0;
			irq_latch_q <= '0;
			irq_cnt_q   <= '0;
			tile_q      <= '0;
			irq_pend_q  <= 1'b0;
		end else if (accept) begin
			control_q   <= control_nxt;
			prg_q       <= prg_nxt;
			chr_q       <= chr_nxt;
			irq_en_q    <= irq_en_nxt;
			irq_latch_q <= irq_latch_nxt;
			irq_cnt_q   <= irq_cnt_nxt;
			irq_pend_q  <= irq_pend_nxt;
			if (is_sreset) begin
				jumper_q <= !jumper_q;
			end
			if (ppu_tile) begin
				tile_q <= addr[ATTR_AW-1:0];
			end
		end
	end

	// Attribute table: clearing pass and CPU writes share the write port.
	// Reads and writes come from distinct requests, so a read always sees
	// every earlier write.
	logic                ram_we, ram_re;
	logic [TABLE_AW-1:0] ram_waddr, ram_raddr;
	logic [1:0]          ram_wdata, ram_rdata;

	assign ram_we    = clr_busy || (accept && wr_attr);
	assign ram_waddr = clr_busy ? clr_q[TABLE_AW-1:0] : {addr[10], addr[ATTR_AW-1:0]};
	assign ram_wdata = clr_busy ? 2'b00 : wdata[1:0];
	assign ram_re    = accept && ppu_attr;
	assign ram_raddr = {half, tile_q};

	cmirq_ram #(
		.WIDTH (2),
		.DEPTH (TABLE_DEPTH)
	) u_attr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Stage s1: hold until the output register takes it; the RAM output
	// holds too, since no new read issues while s1 is blocked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_attr_s1 <= ppu_attr;
			rdata_s1   <= rd_jumper ? {jumper_q, JUMPER_BASE} : 8'h00;
			hit_s1     <= rd_jumper || ppu_attr;
			snd_s1     <= wr_snd || rd_snd;
			status_s1  <= status_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q) begin
			out_rdata_q  <= s1_attr_s1 ? attr_expand(ram_rdata) : rdata_s1;
			out_hit_q    <= hit_s1;
			out_snd_q    <= snd_s1;
			out_status_q <= status_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_status_q, out_snd_q, out_hit_q, out_rdata_q};

`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_no_req_while_clearing, !(clr_busy && s_tready), "request taken during clear")
	`ASSERT_ALWAYS(a_irq_en_pend_excl, !(irq_en_q && irq_pend_q), "irq enabled while pending")
	`ASSERT_ALWAYS(a_ram_rw_excl, !(ram_we && ram_re), "table read and write in one cycle")
	`ASSERT_NEXT(a_attr_read_lands, ram_re, s1_valid_q && s1_attr_s1, "attribute read lost")

endmodule
